// ----- sv/cppt_pkg.sv -----
// Shared types and constants for the convex polygon point test.
package cppt_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned CoordBitsDef   = 31;

  // Item kinds on the input stream
  typedef enum logic [1:0] {
    KindLoad    = 2'd0,
    KindPrepare = 2'd1,
    KindQuery   = 2'd2,
    KindClear   = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatNotReady = 2'd1,
    StatOverflow = 2'd2
  } status_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,
    OpClear,
    OpPrepInit,
    OpPrepRead,
    OpPrepCmp,
    OpPrepDone,
    OpQInit,
    OpReadFan,
    OpLatchF,
    OpLatchL,
    OpCross,
    OpSearchStep,
    OpLatchA,
    OpLatchB
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] sel;   // fan index and cross product selector
  } cmd_t;

  typedef struct packed {
    logic ready;       // polygon prepared with at least three vertices
    logic overflow;
    logic full;        // store full
    logic scan_done;   // prepare scan finished
    logic search_done; // binary search interval narrowed to one edge
  } stat_t;

endpackage

// ----- sv/cppt_ram.sv -----
// Generic single port RAM with registered read.
module cppt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- sv/cppt_datapath.sv -----
// Datapath: vertex store, origin, search indices, cross products and sums.
module cppt_datapath import cppt_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned CoordBits   = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [CoordBits-1:0] x_i,
  input  logic [CoordBits-1:0] y_i,
  output stat_t                stat_o,
  output logic                 inside_o,
  output logic                 reject_o
);

  localparam int unsigned AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam int unsigned DW = CoordBits + 1;   // difference width
  localparam int unsigned PW = 2 * DW;          // product width
  localparam int unsigned XW = PW + 1;          // cross width
  localparam int unsigned SW = XW + 3;          // area sum width

  logic [CW-1:0] count_q;
  logic [AW-1:0] start_q, best_q, scan_q;
  logic signed [CoordBits-1:0] ox_q, oy_q, bx_q, by_q;
  logic ready_q, ovf_q;
  logic [AW-1:0] addr;
  logic we;
  logic [2*CoordBits-1:0] rdata;

  // Search bounds are fan indices
  logic [CW-1:0] lo_q, hi_q, mid;
  logic signed [DW-1:0] px_q, py_q, fx_q, fy_q, lx_q, ly_q, ax_q, ay_q, cx_q, cy_q;
  logic signed [XW-1:0] c0p_q, clp_q, ab_q, ap_q, bp_q, cfl_q, clf_q;
  logic signed [PW-1:0] m1_q, m2_q;
  logic [3:0] cstep_q;
  logic [CW-1:0] fan_i;

  // Fan index to store address: (start + 1 + i) mod count
  logic [CW:0] fsum;
  logic [CW-1:0] fan_addr;
  assign fsum = {1'b0, CW'(start_q)} + (CW+1)'(1) + {1'b0, fan_i};
  always_comb begin
    fan_addr = fsum[CW-1:0];
    if (fsum >= {1'b0, count_q}) fan_addr = CW'(fsum - {1'b0, count_q});
    if ({1'b0, fan_addr} >= {1'b0, count_q}) fan_addr = CW'(fan_addr - count_q);
  end

  assign mid = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  always_comb begin
    unique case (cmd_i.sel)
      4'd0:    fan_i = '0;
      4'd1:    fan_i = count_q - CW'(2);
      4'd2:    fan_i = mid;
      4'd3:    fan_i = lo_q;
      default: fan_i = lo_q + CW'(1);
    endcase
  end

  always_comb begin
    we   = 1'b0;
    addr = fan_addr[AW-1:0];
    unique case (cmd_i.op)
      OpLoad:     begin we = ~stat_o.full; addr = count_q[AW-1:0]; end
      OpPrepRead: addr = scan_q;
      default:    ;
    endcase
  end

  cppt_ram #(.Width(2 * CoordBits), .Depth(MaxVertices)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i({y_i, x_i}), .rdata_o(rdata)
  );

  logic signed [CoordBits-1:0] rx, ry;
  logic signed [DW-1:0] dx, dy;
  assign rx = rdata[CoordBits-1:0];
  assign ry = rdata[2*CoordBits-1:CoordBits];
  assign dx = DW'(rx) - DW'(ox_q);
  assign dy = DW'(ry) - DW'(oy_q);

  // Current vertex beats the best so far: least x, then least y
  logic prep_better;
  assign prep_better = (scan_q == '0) || (rx < bx_q) || (rx == bx_q && ry < by_q);

  // Cross product operand select: u x v = ux*vy - uy*vx, two products then subtract
  logic signed [DW-1:0] ux, uy, vx, vy;
  always_comb begin
    ux = fx_q; uy = fy_q; vx = px_q; vy = py_q;
    unique case (cmd_i.sel)
      4'd0:    begin ux = fx_q; uy = fy_q; vx = px_q; vy = py_q; end
      4'd1:    begin ux = fx_q; uy = fy_q; vx = lx_q; vy = ly_q; end
      4'd2:    begin ux = lx_q; uy = ly_q; vx = px_q; vy = py_q; end
      4'd3:    begin ux = lx_q; uy = ly_q; vx = fx_q; vy = fy_q; end
      4'd4:    begin ux = cx_q; uy = cy_q; vx = px_q; vy = py_q; end
      4'd5:    begin ux = ax_q; uy = ay_q; vx = cx_q; vy = cy_q; end
      4'd6:    begin ux = ax_q; uy = ay_q; vx = px_q; vy = py_q; end
      4'd7:    begin ux = cx_q; uy = cy_q; vx = px_q; vy = py_q; end
      4'd8:    begin ux = fx_q; uy = fy_q; vx = fy_q; vy = fx_q; end
      default: begin ux = px_q; uy = py_q; vx = py_q; vy = px_q; end
    endcase
  end
  // Squared lengths reuse the same multipliers: sel 8 gives fx*fx and fy*fy
  logic signed [XW-1:0] cross_now;
  assign cross_now = XW'(m1_q) - XW'(m2_q);
  logic signed [XW-1:0] sq_now;
  assign sq_now = XW'(m1_q) + XW'(m2_q);

  // Sign helpers
  function automatic logic [1:0] sg(input logic signed [XW-1:0] v);
    sg = (v == '0) ? 2'd0 : (v[XW-1] ? 2'd2 : 2'd1);
  endfunction

  logic signed [SW-1:0] s2, sabs;
  always_comb begin
    s2 = SW'(ab_q) - SW'(ap_q) + SW'(bp_q);
    sabs = s2[SW-1] ? -s2 : s2;
  end
  logic signed [SW-1:0] s1, s2t;
  assign s1  = ab_q[XW-1] ? -SW'(ab_q) : SW'(ab_q);
  assign s2t = sabs + (bp_q[XW-1] ? -SW'(bp_q) : SW'(bp_q))
                    + (ap_q[XW-1] ? -SW'(ap_q) : SW'(ap_q));

  always_comb begin
    reject_o = ((c0p_q != '0) && (sg(c0p_q) != sg(cfl_q))) ||
               ((clp_q != '0) && (sg(clp_q) != sg(clf_q)));
    inside_o = (s1 == s2t);
    if (c0p_q == '0) inside_o = (cfl_q >= clf_q); // reused for squared lengths
  end

  assign stat_o.ready       = ready_q;
  assign stat_o.overflow    = ovf_q;
  assign stat_o.full        = (count_q == CW'(MaxVertices));
  assign stat_o.scan_done   = ({1'b0, scan_q} + (AW+1)'(1) >= (AW+1)'(count_q));
  assign stat_o.search_done = (hi_q - lo_q <= CW'(1));

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; start_q <= '0; ox_q <= '0; oy_q <= '0;
      ready_q <= 1'b0; ovf_q <= 1'b0; scan_q <= '0; best_q <= '0;
      bx_q <= '0; by_q <= '0;
      lo_q <= '0; hi_q <= '0; cstep_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpLoad: begin
          if (stat_o.full) ovf_q <= 1'b1;
          else count_q <= count_q + CW'(1);
          ready_q <= 1'b0;
        end
        OpClear: begin
          count_q <= '0; start_q <= '0; ox_q <= '0; oy_q <= '0;
          ready_q <= 1'b0; ovf_q <= 1'b0;
        end
        OpPrepInit: begin
          ready_q <= 1'b0; scan_q <= '0; best_q <= '0;
        end
        OpPrepCmp: begin
          if (prep_better) begin
            best_q <= scan_q; bx_q <= rx; by_q <= ry;
          end
          scan_q <= scan_q + AW'(1);
        end
        OpPrepDone: begin
          // last vertex is compared here; fewer than three vertices leaves it not ready
          if (count_q >= CW'(3)) begin
            if (prep_better) begin
              start_q <= scan_q; ox_q <= rx; oy_q <= ry;
            end else begin
              start_q <= best_q; ox_q <= bx_q; oy_q <= by_q;
            end
            ready_q <= 1'b1;
          end
        end
        OpQInit: begin
          lo_q <= '0; hi_q <= count_q - CW'(2);
        end
        OpSearchStep: begin
          if (!cross_now[XW-1]) lo_q <= mid; else hi_q <= mid;
        end
        default: ;
      endcase
      cstep_q <= cmd_i.sel;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    m1_q <= ux * vy;
    m2_q <= uy * vx;
    unique case (cmd_i.op)
      OpQInit: begin
        px_q <= DW'($signed(x_i)) - DW'(ox_q);
        py_q <= DW'($signed(y_i)) - DW'(oy_q);
      end
      OpLatchF: begin fx_q <= dx; fy_q <= dy; end
      OpLatchL: begin lx_q <= dx; ly_q <= dy; end
      OpLatchA: begin ax_q <= dx; ay_q <= dy; cx_q <= dx; cy_q <= dy; end
      OpLatchB: begin cx_q <= dx; cy_q <= dy; end
      OpCross: begin
        // products of selector cstep_q are ready now
        unique case (cstep_q)
          4'd0: c0p_q <= cross_now;
          4'd1: cfl_q <= cross_now;
          4'd2: clp_q <= cross_now;
          4'd3: clf_q <= cross_now;
          4'd5: ab_q  <= cross_now;
          4'd6: ap_q  <= cross_now;
          4'd7: bp_q  <= cross_now;
          4'd8: cfl_q <= sq_now;
          4'd9: clf_q <= sq_now;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/cppt_ctrl.sv -----
// Controller: sequences loads, prepare scan and query steps.
module cppt_ctrl import cppt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  kind_e  kind_i,
  input  stat_t  stat_i,
  input  logic   inside_i,
  input  logic   reject_i,
  output cmd_t   cmd_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output logic   out_inside_o,
  output status_e out_status_o
);

  typedef enum logic [5:0] {
    SIdle, SPrepRd, SPrepWt, SPrepCmp,
    SRdF, SWtF, SRdL, SWtL,
    SMul0, SMul1, SMul2, SMul3, SX0, SX1, SX2, SX3, SChk,
    SSqF, SSqP, SSqW, SSqFd, SSqPd, SSqDone,
    SSrRd, SSrWt, SSrMul, SSrX, SSrStep,
    SRdA, SWtA, SRdB, SWtB, SMulT, SXT, SFin
  } state_e;

  state_e state_q;
  logic [3:0] k_q;  // triangle cross counter
  logic       busy_out;
  logic       out_set;

  assign busy_out   = out_valid_o && !out_ready_i;
  assign in_ready_o = (state_q == SIdle) && !busy_out;

  // A result word is loaded this cycle
  assign out_set = (state_q == SIdle && in_valid_i && in_ready_o &&
                    kind_i == KindQuery && !stat_i.ready) ||
                   (state_q == SX2 && reject_i) ||
                   (state_q == SFin);

  always_comb begin
    cmd_o = '{op: OpNone, sel: 4'd0};
    unique case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        unique case (kind_i)
          KindLoad:    cmd_o.op = OpLoad;
          KindClear:   cmd_o.op = OpClear;
          KindPrepare: cmd_o.op = OpPrepInit;
          KindQuery:   cmd_o.op = OpQInit;
        endcase
      end
      SPrepRd:  cmd_o.op = OpPrepRead;
      SPrepWt:  cmd_o.op = OpPrepRead;
      SPrepCmp: cmd_o.op = stat_i.scan_done ? OpPrepDone : OpPrepCmp;
      SRdF:     cmd_o = '{op: OpReadFan, sel: 4'd0};
      SWtF:     cmd_o = '{op: OpLatchF, sel: 4'd0};
      SRdL:     cmd_o = '{op: OpReadFan, sel: 4'd1};
      SWtL:     cmd_o = '{op: OpLatchL, sel: 4'd1};
      SMul0:    cmd_o.sel = 4'd0;
      SMul1:    cmd_o = '{op: OpCross, sel: 4'd1};
      SMul2:    cmd_o = '{op: OpCross, sel: 4'd2};
      SMul3:    cmd_o = '{op: OpCross, sel: 4'd3};
      SX0:      cmd_o = '{op: OpCross, sel: 4'd0};
      SSqF:     cmd_o.sel = 4'd8;
      SSqP:     cmd_o = '{op: OpCross, sel: 4'd9};
      SSqW:     cmd_o = '{op: OpCross, sel: 4'd0};
      SSrRd:    cmd_o = '{op: OpReadFan, sel: 4'd2};
      SSrWt:    cmd_o = '{op: OpLatchA, sel: 4'd2};
      SSrMul:   cmd_o.sel = 4'd4;
      SSrX:     cmd_o = '{op: OpNone, sel: 4'd4};
      SSrStep:  cmd_o = '{op: OpSearchStep, sel: 4'd2};
      SRdA:     cmd_o = '{op: OpReadFan, sel: 4'd3};
      SWtA:     cmd_o = '{op: OpLatchA, sel: 4'd3};
      SRdB:     cmd_o = '{op: OpReadFan, sel: 4'd10};
      SWtB:     cmd_o = '{op: OpLatchB, sel: 4'd10};
      SMulT:    cmd_o.sel = 4'(4'd5 + k_q);
      SXT:      cmd_o = '{op: OpCross, sel: 4'(4'd4 + k_q)};
      default:  ;
    endcase
  end

  // Sequencing of states and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; k_q <= '0;
      out_valid_o <= 1'b0; out_inside_o <= 1'b0; out_status_o <= StatOk;
    end else begin
      if (out_valid_o && out_ready_i && !out_set) out_valid_o <= 1'b0;
      unique case (state_q)
        SIdle: if (in_valid_i && in_ready_o) begin
          priority if (kind_i == KindPrepare) begin
            state_q <= SPrepRd;
          end else if (kind_i == KindQuery) begin
            if (!stat_i.ready) begin
              out_valid_o <= 1'b1; out_inside_o <= 1'b0;
              out_status_o <= StatNotReady;
            end else state_q <= SRdF;
          end
        end
        SPrepRd:  state_q <= SPrepWt;
        SPrepWt:  state_q <= SPrepCmp;
        SPrepCmp: state_q <= stat_i.scan_done ? SIdle : SPrepRd;
        SRdF:  state_q <= SWtF;
        SWtF:  state_q <= SRdL;
        SRdL:  state_q <= SWtL;
        SWtL:  state_q <= SMul0;
        SMul0: state_q <= SMul1;
        SMul1: state_q <= SMul2;
        SMul2: state_q <= SMul3;
        SMul3: state_q <= SX0;
        SX0:   state_q <= SChk;
        SChk:  state_q <= SX1;
        SX1:   state_q <= SX2;
        SX2: begin
          if (reject_i) begin
            out_valid_o <= 1'b1; out_inside_o <= 1'b0;
            out_status_o <= stat_i.overflow ? StatOverflow : StatOk;
            state_q <= SIdle;
          end else state_q <= SX3;
        end
        SX3:   state_q <= SSqF;
        SSqF:  state_q <= SSqP;
        SSqP:  state_q <= SSqW;
        SSqW:  state_q <= SSqFd;
        SSqFd: state_q <= SSqPd;
        SSqPd: state_q <= SSqDone;
        SSqDone: begin
          state_q <= stat_i.search_done ? SRdA : SSrRd;
        end
        SSrRd:   state_q <= SSrWt;
        SSrWt:   state_q <= SSrMul;
        SSrMul:  state_q <= SSrX;
        SSrX:    state_q <= SSrStep;
        SSrStep: state_q <= SSqDone;
        SRdA:  state_q <= SWtA;
        SWtA:  state_q <= SRdB;
        SRdB:  state_q <= SWtB;
        SWtB:  begin k_q <= '0; state_q <= SMulT; end
        SMulT: state_q <= SXT;
        SXT: begin
          if (k_q == 4'd2) state_q <= SFin;
          else begin k_q <= k_q + 4'd1; state_q <= SMulT; end
        end
        SFin: begin
          out_valid_o <= 1'b1; out_inside_o <= inside_i;
          out_status_o <= stat_i.overflow ? StatOverflow : StatOk;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_status_o))
    else $error("result word changed while stalled");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> !in_ready_o)
    else $error("input accepted while busy");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_status_o == StatOk || out_status_o == StatNotReady ||
                     out_status_o == StatOverflow))
    else $error("bad status code");

endmodule

// ----- sv/convex_polygon_point_test.sv -----
// Top level of the convex polygon point test.
// Loads, clears and not-ready queries are handled from the idle state; a prepare scans
// the store one vertex at a time; a query steps through a wedge check, a binary search
// and a triangle test, ending early when the point falls outside the wedge, in steps set by the
// single-port vertex memory and the shared cross-product multipliers. No word is taken while a result waits.
module convex_polygon_point_test import cppt_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned CoordBits   = CoordBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [(2*CoordBits+7)/8*8-1:0] s_axis_tdata,  // coord_x, coord_y, zero pad
  input  logic [1:0] s_axis_tuser,   // kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // inside_res, status, zero pad
);

  cmd_t cmd;
  stat_t stat;
  logic in_poly, reject, out_inside;
  status_e out_status;

  cppt_datapath #(.MaxVertices(MaxVertices), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .x_i(s_axis_tdata[CoordBits-1:0]),
    .y_i(s_axis_tdata[2*CoordBits-1:CoordBits]),
    .stat_o(stat), .inside_o(in_poly), .reject_o(reject)
  );

  cppt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(kind_e'(s_axis_tuser)), .stat_i(stat), .inside_i(in_poly),
    .reject_i(reject), .cmd_o(cmd), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .out_inside_o(out_inside), .out_status_o(out_status)
  );

  assign m_axis_tdata = {5'd0, out_status, out_inside};

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the convex polygon point test.
module testbench import cppt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumVert = MaxVerticesDef;
  localparam int unsigned LongHold = 3000;

  typedef struct packed {
    kind_e             kind;
    logic signed [30:0] cx;
    logic signed [30:0] cy;
  } word_t;

  typedef struct packed {
    logic    hit;
    status_e stat;
  } verdict_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;

  convex_polygon_point_test u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor state
  longint    poly_x [NumVert];
  longint    poly_y [NumVert];
  int unsigned n_vert;
  int unsigned first_idx;
  longint    org_x, org_y;
  bit        is_ready, is_overflow;

  word_t    pending_words[$];
  verdict_t expected_verdicts[$];
  int       n_errors;
  int       n_checked;
  int       n_inside;
  int       send_idle_pct, recv_idle_pct;
  bit       hold_recv;
  bit       hold_start;

  function automatic int sgn(longint v);
    return v > 0 ? 1 : (v == 0 ? 0 : -1);
  endfunction

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic void fan_vertex(int unsigned i, output longint x, output longint y);
    int unsigned k;
    k = (first_idx + 1 + i) % n_vert;
    x = poly_x[k] - org_x;
    y = poly_y[k] - org_y;
  endfunction

  // Wedge check, ray check, binary search and area sum
  function automatic bit point_inside(longint qx, longint qy);
    int unsigned n, lo, hi, mid;
    longint px, py, fx, fy, lx, ly, ax, ay, bx, by, c0p, clp, ab, ap, bp;
    logic [127:0] df, dp;
    logic signed [127:0] s1, s2, t;
    n  = n_vert - 1;
    px = qx - org_x;
    py = qy - org_y;
    fan_vertex(0, fx, fy);
    fan_vertex(n - 1, lx, ly);
    c0p = cross2(fx, fy, px, py);
    if (c0p != 0 && sgn(c0p) != sgn(cross2(fx, fy, lx, ly))) return 1'b0;
    clp = cross2(lx, ly, px, py);
    if (clp != 0 && sgn(clp) != sgn(cross2(lx, ly, fx, fy))) return 1'b0;
    if (c0p == 0) begin
      // 64-bit wrap as in the model
      df = 128'(fx * fx + fy * fy);
      dp = 128'(px * px + py * py);
      return df[63:0] >= dp[63:0];
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      fan_vertex(mid, ax, ay);
      if (cross2(ax, ay, px, py) >= 0) lo = mid;
      else hi = mid;
    end
    fan_vertex(lo, ax, ay);
    fan_vertex(lo + 1, bx, by);
    ab = cross2(ax, ay, bx, by);
    ap = cross2(ax, ay, px, py);
    bp = cross2(bx, by, px, py);
    s1 = 128'(signed'(ab));
    if (s1 < 0) s1 = -s1;
    t  = 128'(signed'(ab)) - 128'(signed'(ap)) + 128'(signed'(bp));
    s2 = (t < 0) ? -t : t;
    t  = 128'(signed'(bp));
    s2 = s2 + ((t < 0) ? -t : t);
    t  = 128'(signed'(ap));
    s2 = s2 + ((t < 0) ? -t : t);
    return s1 == s2;
  endfunction

  // Apply one accepted word to the predictor
  task automatic predict_word(word_t w);
    verdict_t v;
    int unsigned best;
    case (w.kind)
      KindLoad: begin
        if (n_vert >= NumVert) is_overflow = 1'b1;
        else begin
          poly_x[n_vert] = w.cx;
          poly_y[n_vert] = w.cy;
          n_vert++;
        end
        is_ready = 1'b0;
      end
      KindPrepare: begin
        is_ready = 1'b0;
        if (n_vert >= 3) begin
          best = 0;
          for (int unsigned i = 1; i < n_vert; i++)
            if (poly_x[i] < poly_x[best] ||
                (poly_x[i] == poly_x[best] && poly_y[i] < poly_y[best])) best = i;
          first_idx = best;
          org_x = poly_x[best];
          org_y = poly_y[best];
          is_ready = 1'b1;
        end
      end
      KindClear: begin
        n_vert = 0;
        first_idx = 0;
        org_x = 0;
        org_y = 0;
        is_ready = 1'b0;
        is_overflow = 1'b0;
      end
      default: begin
        if (!is_ready || n_vert < 3) begin
          v.hit = 1'b0;
          v.stat = StatNotReady;
        end else begin
          v.hit = point_inside(w.cx, w.cy);
          v.stat = is_overflow ? StatOverflow : StatOk;
        end
        expected_verdicts.push_back(v);
      end
    endcase
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= KindLoad;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(pending_words.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, pending_words[0].cy, pending_words[0].cx};
          s_axis_tuser  <= pending_words[0].kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver readiness
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          n_errors++;
        end else begin
          want = expected_verdicts.pop_front();
          n_checked++;
          if (want.hit) n_inside++;
          if (m_axis_tdata[0] !== want.hit) begin
            $error("inside_res expected %0d actual %0d", want.hit, m_axis_tdata[0]);
            n_errors++;
          end
          if (m_axis_tdata[2:1] !== want.stat) begin
            $error("status expected %0d actual %0d", want.stat, m_axis_tdata[2:1]);
            n_errors++;
          end
        end
      end
      m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold, counted in clock cycles
  initial begin
    hold_recv = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    hold_recv <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    hold_recv <= 1'b0;
  end

  function automatic word_t mk(kind_e k, longint x, longint y);
    word_t w;
    w.kind = k;
    w.cx = 31'(x);
    w.cy = 31'(y);
    return w;
  endfunction

  function automatic longint rnd_coord();
    case ($urandom_range(3))
      0: return longint'($signed(31'($urandom)));
      1: return longint'($urandom_range(40)) - 20;
      2: return $urandom_range(1) ? 64'sd1073741823 : -64'sd1073741824;
      default: return longint'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  // Queue a random convex polygon: points spaced evenly on a circle, then a prepare and queries
  task automatic push_polygon(int unsigned nv, longint r);
    longint cx, cy;
    int unsigned rot;
    real a;
    cx = longint'($urandom_range(2000)) - 1000;
    cy = longint'($urandom_range(2000)) - 1000;
    rot = $urandom_range(nv - 1);
    for (int unsigned i = 0; i < nv; i++) begin
      a = 6.283185307 * real'((i + rot) % nv) / real'(nv);
      pending_words.push_back(mk(KindLoad, cx + longint'(r * $cos(a)),
                                 cy + longint'(r * $sin(a))));
    end
    pending_words.push_back(mk(KindPrepare, 0, 0));
    for (int unsigned i = 0; i < 6; i++)
      pending_words.push_back(mk(KindQuery, cx + longint'($urandom_range(2 * r + 4)) - r - 2,
                                 cy + longint'($urandom_range(2 * r + 4)) - r - 2));
    pending_words.push_back(mk(KindQuery, cx, cy));
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    longint big;
    int unsigned nv;
    n_errors = 0;
    n_checked = 0;
    n_inside = 0;
    send_idle_pct = 6;
    recv_idle_pct = 61;
    n_vert = 0;
    first_idx = 0;
    org_x = 0;
    org_y = 0;
    is_ready = 1'b0;
    is_overflow = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: not ready, too few vertices, extremes, ray, load after prepare
    big = 64'sd1073741823;
    pending_words.push_back(mk(KindQuery, 0, 0));
    pending_words.push_back(mk(KindLoad, -big - 1, -big - 1));
    pending_words.push_back(mk(KindLoad, big, -big - 1));
    pending_words.push_back(mk(KindPrepare, 0, 0));
    pending_words.push_back(mk(KindQuery, 0, 0));
    pending_words.push_back(mk(KindLoad, big, big));
    pending_words.push_back(mk(KindQuery, 0, 0));
    pending_words.push_back(mk(KindLoad, -big - 1, big));
    pending_words.push_back(mk(KindPrepare, 0, 0));
    pending_words.push_back(mk(KindQuery, 0, 0));
    pending_words.push_back(mk(KindQuery, big, big));
    pending_words.push_back(mk(KindQuery, -big - 1, -big - 1));
    pending_words.push_back(mk(KindQuery, 0, -big - 1));
    pending_words.push_back(mk(KindQuery, big, 0));
    pending_words.push_back(mk(KindQuery, -big - 1, 0));
    pending_words.push_back(mk(KindQuery, -5, -big - 1));
    pending_words.push_back(mk(KindLoad, 0, 0));
    pending_words.push_back(mk(KindQuery, 1, 1));
    pending_words.push_back(mk(KindClear, 0, 0));
    pending_words.push_back(mk(KindQuery, 1, 1));
    wait_drained();

    // Overflow: fill the store, then one dropped load
    push_polygon(NumVert, 1000000);
    pending_words.push_back(mk(KindLoad, 3, 3));
    pending_words.push_back(mk(KindPrepare, 0, 0));
    for (int i = 0; i < 8; i++) pending_words.push_back(mk(KindQuery, rnd_coord(), rnd_coord()));
    pending_words.push_back(mk(KindClear, 0, 0));
    wait_drained();

    // Random, three idling phases; long receiver hold in the first
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 6 : 0;
      for (int g = 0; g < 7; g++) begin
        if ($urandom_range(9) < 8) begin
          nv = ($urandom_range(9) == 0) ? $urandom_range(64, 3) : $urandom_range(8, 3);
          push_polygon(nv, $urandom_range(1) ? 1000 : 400000000);
        end else begin
          for (int i = 0; i < 4; i++)
            pending_words.push_back(mk(kind_e'($urandom_range(3)), rnd_coord(), rnd_coord()));
        end
        if ($urandom_range(3) == 0) pending_words.push_back(mk(KindClear, 0, 0));
      end
      if (phase == 0) hold_start = 1'b1;
      wait_drained();
    end

    $display("Checked %0d query results (%0d inside) over polygons of 3 to %0d vertices,",
             n_checked, n_inside, NumVert);
    $display("including not-ready, overflow and boundary cases under three stall patterns.");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
